>>> rtl/cfra_pkg.sv
// ----------------------------------------------------------------------------
// cfra_pkg: shared types and constants
// Widths, register indexes and sequencer states for the continued-fraction
// rational approximation block.
// ----------------------------------------------------------------------------
package cfra_pkg;

    localparam int FRAC_BITS = 32;
    localparam int VAL_W     = 64;
    localparam int LIM_W     = 31;
    localparam int NUM_W     = 32;
    localparam int CFG_IDX_W = 2;

    // divider operand width: dividends after the first step are at most 2^FRAC_BITS
    localparam int DW    = FRAC_BITS + 1;
    // partial quotient width: first one can reach 2^(63-FRAC_BITS), later ones <= 1e9
    localparam int AW    = (VAL_W - FRAC_BITS > 30) ? (VAL_W - FRAC_BITS) : 30;
    localparam int PW    = AW + LIM_W;
    localparam int SW    = PW + 1;
    localparam int CNT_W = $clog2(DW);

    localparam logic [63:0]      MAX_PQ        = 64'd1000000000;
    localparam logic [LIM_W-1:0] NUMER_LIM_RST = LIM_W'(32000);
    localparam logic [LIM_W-1:0] DENOM_LIM_RST = LIM_W'(4000);

    localparam logic [CFG_IDX_W-1:0] CFG_NUMER_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DENOM_LIMIT = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MULP,
        ST_MULQ,
        ST_CHK,
        ST_FIN
    } t_state;

endpackage

>>> rtl/cfra_in_if.sv
// ----------------------------------------------------------------------------
// cfra_in_if: input request channel
// Valid/ready channel carrying one fixed-point value to approximate.
// ----------------------------------------------------------------------------
interface cfra_in_if import cfra_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> rtl/cfra_out_if.sv
// ----------------------------------------------------------------------------
// cfra_out_if: result request channel
// Valid/ready channel carrying one numerator/denominator pair.
// ----------------------------------------------------------------------------
interface cfra_out_if import cfra_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [NUM_W-1:0] numerator;
    logic [LIM_W-1:0]        denominator;

    modport source (output valid, output numerator, output denominator, input ready);
    modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

>>> rtl/continued_fraction_rational_approx.sv
// ----------------------------------------------------------------------------
// continued_fraction_rational_approx: best rational approximation
// Turns a signed Q31.32 value into numerator/denominator, the last
// continued-fraction convergent within the configured limits.
// ----------------------------------------------------------------------------
// Usage: write numer_limit (index 0) and denom_limit (index 1) while idle,
// then send one value per request. The block takes one request at a time and
// drops ready until its result is handed to the output register, which holds
// it until the sink takes it. The integer part needs one multiply for the
// numerator candidate, one for the denominator candidate and one limit
// check; every further partial quotient first runs the one-bit-per-cycle
// restoring divider and then the same steps on the shared multiplier and
// check. A zero value goes straight to the output as 0/1. The loop stops
// on an exact remainder, on a convergent beyond a limit (the previous one
// is kept, so 1/0 can come out) or on a partial quotient above one billion.
// ----------------------------------------------------------------------------
module continued_fraction_rational_approx import cfra_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LIM_W-1:0]     i_cfg_wdata,
    cfra_in_if.sink              i_in,
    cfra_out_if.source           o_out
);

    // control state
    t_state           r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic [LIM_W-1:0] r_numer_lim, r_denom_lim;

    // datapath
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DW-1:0]    r_quo, n_quo;      // dividend shifts out, quotient shifts in
    logic [DW-1:0]    r_rem, n_rem;
    logic [DW-1:0]    r_den, n_den;      // current divisor
    logic [DW-1:0]    r_r, n_r;          // remainder of the last division
    logic [AW-1:0]    r_a, n_a;          // current partial quotient
    logic [LIM_W-1:0] r_p0, n_p0, r_q0, n_q0, r_p1, n_p1, r_q1, n_q1;
    logic [LIM_W-1:0] r_p2, n_p2;
    logic             r_over_p, n_over_p;
    logic [PW-1:0]    r_prod, n_prod;
    logic             r_neg, n_neg;
    logic [LIM_W-1:0] r_res_p, n_res_p, r_res_q, n_res_q;
    logic [NUM_W-1:0] r_out_num, n_out_num;
    logic [LIM_W-1:0] r_out_den, n_out_den;

    // combinational helpers
    logic [VAL_W-1:0] mag;
    logic [DW:0]      div_trial, div_diff;
    logic [DW-1:0]    div_quo, div_rem;
    logic [AW-1:0]    mul_a;
    logic [LIM_W-1:0] mul_b;
    logic [PW-1:0]    mul_y;
    logic [SW-1:0]    sum_p, sum_q;
    logic [NUM_W-1:0] res_mag;

    // one restoring divider step
    always_comb begin
        div_trial = {r_rem, r_quo[DW-1]};
        div_diff  = div_trial - {1'b0, r_den};
        if (!div_diff[DW]) begin
            div_rem = div_diff[DW-1:0];
            div_quo = {r_quo[DW-2:0], 1'b1};
        end else begin
            div_rem = div_trial[DW-1:0];
            div_quo = {r_quo[DW-2:0], 1'b0};
        end
    end

    // shared multiplier: numerator term in MULP, denominator term in MULQ
    assign mul_a = r_a;
    assign mul_b = (r_state == ST_MULP) ? r_p1 : r_q1;
    assign mul_y = PW'(mul_a) * PW'(mul_b);

    assign mag     = i_in.value[VAL_W-1] ? (VAL_W'(0) - i_in.value) : i_in.value;
    assign sum_p   = SW'(r_p0) + SW'(r_prod);
    assign sum_q   = SW'(r_q0) + SW'(r_prod);
    assign res_mag = {1'b0, r_res_p};

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.numerator   = r_out_num;
    assign o_out.denominator = r_out_den;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_cnt       = r_cnt;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_den       = r_den;
        n_r         = r_r;
        n_a         = r_a;
        n_p0        = r_p0;
        n_q0        = r_q0;
        n_p1        = r_p1;
        n_q1        = r_q1;
        n_p2        = r_p2;
        n_over_p    = r_over_p;
        n_prod      = r_prod;
        n_neg       = r_neg;
        n_res_p     = r_res_p;
        n_res_q     = r_res_q;
        n_out_num   = r_out_num;
        n_out_den   = r_out_den;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_neg = i_in.value[VAL_W-1];
                    n_p0  = '0;
                    n_q0  = LIM_W'(1);
                    n_p1  = LIM_W'(1);
                    n_q1  = '0;
                    if (mag == '0) begin
                        n_res_p = '0;
                        n_res_q = LIM_W'(1);
                        n_state = ST_FIN;
                    end else begin
                        // integer part is a shift; no quotient cap on it
                        n_a     = AW'(mag >> FRAC_BITS);
                        n_r     = DW'(mag[FRAC_BITS-1:0]);
                        n_den   = DW'(1) << FRAC_BITS;
                        n_state = ST_MULP;
                    end
                end
            end
            ST_DIV: begin
                n_quo = div_quo;
                n_rem = div_rem;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DW - 1)) begin
                    if (64'(div_quo) > MAX_PQ) begin
                        n_res_p = r_p1;
                        n_res_q = r_q1;
                        n_state = ST_FIN;
                    end else begin
                        n_a     = AW'(div_quo);
                        n_r     = div_rem;
                        n_state = ST_MULP;
                    end
                end
            end
            ST_MULP: begin
                n_prod  = mul_y;
                n_state = ST_MULQ;
            end
            ST_MULQ: begin
                n_over_p = (sum_p > SW'(r_numer_lim));
                n_p2     = sum_p[LIM_W-1:0];
                n_prod   = mul_y;
                n_state  = ST_CHK;
            end
            ST_CHK: begin
                if (r_over_p || (sum_q > SW'(r_denom_lim))) begin
                    n_res_p = r_p1;
                    n_res_q = r_q1;
                    n_state = ST_FIN;
                end else if (r_r == '0) begin
                    n_res_p = r_p2;
                    n_res_q = sum_q[LIM_W-1:0];
                    n_state = ST_FIN;
                end else begin
                    // shift convergents, next Euclid step divides den by r
                    n_p0    = r_p1;
                    n_q0    = r_q1;
                    n_p1    = r_p2;
                    n_q1    = sum_q[LIM_W-1:0];
                    n_quo   = r_den;
                    n_den   = r_r;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_num   = r_neg ? (NUM_W'(0) - res_mag) : res_mag;
                    n_out_den   = r_res_q;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_numer_lim <= NUMER_LIM_RST;
            r_denom_lim <= DENOM_LIM_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && (i_cfg_index == CFG_NUMER_LIMIT)) begin
                r_numer_lim <= i_cfg_wdata;
            end
            if (i_cfg_we && (i_cfg_index == CFG_DENOM_LIMIT)) begin
                r_denom_lim <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_den     <= n_den;
        r_r       <= n_r;
        r_a       <= n_a;
        r_p0      <= n_p0;
        r_q0      <= n_q0;
        r_p1      <= n_p1;
        r_q1      <= n_q1;
        r_p2      <= n_p2;
        r_over_p  <= n_over_p;
        r_prod    <= n_prod;
        r_neg     <= n_neg;
        r_res_p   <= n_res_p;
        r_res_q   <= n_res_q;
        r_out_num <= n_out_num;
        r_out_den <= n_out_den;
    end

endmodule

>>> rtl/cfra_checker.sv
// ----------------------------------------------------------------------------
// cfra_checker: port-level checks
// Watches the request channels of the approximation block over time.
// ----------------------------------------------------------------------------
module cfra_checker import cfra_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [NUM_W-1:0] i_out_numerator,
    input logic [LIM_W-1:0]        i_out_denominator
);

    // one request at a time: busy right after taking one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready high right after an accepted request");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_numerator) && $stable(i_out_denominator)))
        else $error("stalled result changed or dropped");

    // a zero denominator only comes from keeping the 1/0 start convergent
    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_denominator == '0)) |->
            ((i_out_numerator == NUM_W'(1)) || (i_out_numerator == -NUM_W'(1))))
        else $error("zero denominator with numerator other than +-1");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("block not idle after reset");

endmodule

bind continued_fraction_rational_approx cfra_checker u_cfra_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_numerator   (o_out.numerator),
    .i_out_denominator (o_out.denominator)
);
